FILE: src/wbmp_header_parser_top_defines.svh
`ifndef WBMP_HEADER_PARSER_TOP_DEFINES_SVH
`define WBMP_HEADER_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define WHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/whp_pkg.sv
package whp_pkg;

  localparam int unsigned AccW = 64;
  localparam int unsigned DimW = 16;
  localparam logic [DimW-1:0] DimMax = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FIXED    = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_WIDTH    = 3'd3,
    ST_HEIGHT   = 3'd4,
    ST_TRUNC    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_FIX0   = 2'd0,
    PH_FIX1   = 2'd1,
    PH_WIDTH  = 2'd2,
    PH_HEIGHT = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
  } rsp_t;

  typedef struct packed {
    phase_e          phase;
    logic [AccW-1:0] acc;
    logic [DimW-1:0] saved_width;
  } parse_state_t;

  typedef struct packed {
    logic         emit;
    rsp_t         rsp;
    parse_state_t state;
  } step_res_t;

endpackage

FILE: src/whp_step.sv
module whp_step (
  input  whp_pkg::req_t           req_i,
  input  whp_pkg::parse_state_t   state_i,
  input  logic [15:0]             max_dim_i,
  output whp_pkg::step_res_t      res_o
);
  import whp_pkg::*;

  logic [AccW-1:0] acc_shift;
  logic            acc_top;
  logic            bad_val;
  parse_state_t    start_state;

  assign acc_shift = {state_i.acc[AccW-8:0], req_i.data_byte[6:0]};
  assign acc_top   = |state_i.acc[AccW-1:AccW-7];
  assign bad_val   = (acc_shift == '0) || (|acc_shift[AccW-1:DimW])
                     || (acc_shift[DimW-1:0] > max_dim_i);

  always_comb begin
    start_state.phase       = PH_FIX0;
    start_state.acc         = '0;
    start_state.saved_width = '0;
  end

  always_comb begin
    res_o.emit              = 1'b0;
    res_o.rsp.status        = ST_OK;
    res_o.rsp.image_width   = '0;
    res_o.rsp.image_height  = '0;
    res_o.state             = state_i;
    if (req_i.end_of_input) begin
      res_o.emit       = 1'b1;
      res_o.rsp.status = ST_TRUNC;
      res_o.state      = start_state;
    end else begin
      unique case (state_i.phase) inside
        PH_FIX0, PH_FIX1: begin
          if (req_i.data_byte != 8'd0) begin
            res_o.emit       = 1'b1;
            res_o.rsp.status = ST_FIXED;
            res_o.state      = start_state;
          end else begin
            res_o.state.phase = (state_i.phase == PH_FIX0) ? PH_FIX1 : PH_WIDTH;
            res_o.state.acc   = '0;
          end
        end
        PH_WIDTH, PH_HEIGHT: begin
          if (acc_top) begin
            res_o.emit       = 1'b1;
            res_o.rsp.status = ST_OVERFLOW;
            res_o.state      = start_state;
          end else if (req_i.data_byte[7]) begin
            res_o.state.acc = acc_shift;
          end else if (bad_val) begin
            res_o.emit       = 1'b1;
            res_o.rsp.status = (state_i.phase == PH_WIDTH) ? ST_WIDTH : ST_HEIGHT;
            res_o.state      = start_state;
          end else if (state_i.phase == PH_WIDTH) begin
            res_o.state.saved_width = acc_shift[DimW-1:0];
            res_o.state.acc         = '0;
            res_o.state.phase       = PH_HEIGHT;
          end else begin
            res_o.emit             = 1'b1;
            res_o.rsp.status       = ST_OK;
            res_o.rsp.image_width  = state_i.saved_width;
            res_o.rsp.image_height = acc_shift[DimW-1:0];
            res_o.state            = start_state;
          end
        end
        default: begin
          res_o.state = start_state;
        end
      endcase
    end
  end

endmodule

FILE: src/wbmp_header_parser_top.sv
// path: a header byte enters the request register at acceptance; a result it
//   completes is captured in the result register, which drives the output, once that is free
// throughput: one byte per cycle, set by the combinational parse step; stalls
//   only while the result register is held by the consumer
// reset: parser back to the first fixed byte, max_dimension to 65535, no item held
`include "wbmp_header_parser_top_defines.svh"

module wbmp_header_parser_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  whp_pkg::req_t   in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output whp_pkg::rsp_t   out_rsp_o,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i
);
  import whp_pkg::*;

  logic            in_valid_q;
  req_t            in_q;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q;
  parse_state_t    state_q;
  logic [DimW-1:0] max_dim_q;
  step_res_t       step;
  logic            out_free;
  logic            fire;

  whp_step u_step (
    .req_i     (in_q),
    .state_i   (state_q),
    .max_dim_i (max_dim_q),
    .res_o     (step)
  );

  assign out_free    = !out_valid_q || out_ready_i;
  assign fire        = in_valid_q && out_free;
  assign in_ready_o  = !in_valid_q || fire;
  assign out_valid_d = fire ? step.emit : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      state_q.phase     <= PH_FIX0;
      state_q.acc       <= '0;
      state_q.saved_width <= '0;
      max_dim_q         <= DimMax;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= step.state;
      end
      if (cfg_we_i) begin
        max_dim_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
    if (fire && step.emit) begin
      out_q <= step.rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `WHP_ASSERT_NOW(a_dims_zero_on_error,
    out_valid_q && (out_q.status != ST_OK),
    (out_q.image_width == '0) && (out_q.image_height == '0),
    "dimensions nonzero on error status")
  `WHP_ASSERT_NEXT(a_restart_after_result, fire && step.emit,
    (state_q.phase == PH_FIX0) && (state_q.acc == '0),
    "parser not back at start after result")
  `WHP_ASSERT_NEXT(a_request_held, in_valid_q && !fire,
    in_valid_q && $stable(in_q),
    "held request lost or changed")
  `WHP_ASSERT_NEXT(a_result_held, out_valid_q && !out_ready_i,
    out_valid_q && $stable(out_q),
    "pending result lost or changed")

endmodule

FILE: sim/tb.sv
module tb;
  import whp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemTarget = 1700;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  req_t        in_req_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rsp_t        out_rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  // predicts the parse of the byte stream and holds the awaited results
  class header_checker;
    phase_e      ph;
    logic [63:0] acc;
    logic [15:0] saved_w;
    logic [15:0] max_dim;
    rsp_t        awaited_rsp[$];
    int          errors;

    function new();
      max_dim = DimMax;
      errors = 0;
      restart();
    endfunction

    function void restart();
      ph = PH_FIX0;
      acc = '0;
      saved_w = '0;
    endfunction

    function void write_max(logic [15:0] v);
      max_dim = v;
    endfunction

    function void conclude(status_e st, logic [15:0] w, logic [15:0] h);
      rsp_t r;
      r.status = st;
      r.image_width = w;
      r.image_height = h;
      awaited_rsp.push_back(r);
      restart();
    endfunction

    function void note_request(req_t r);
      logic [63:0] v;
      if (r.end_of_input) begin
        conclude(ST_TRUNC, '0, '0);
        return;
      end
      if (ph == PH_FIX0 || ph == PH_FIX1) begin
        if (r.data_byte != 8'h00) begin
          conclude(ST_FIXED, '0, '0);
          return;
        end
        ph = (ph == PH_FIX0) ? PH_FIX1 : PH_WIDTH;
        acc = '0;
        return;
      end
      // any of the top seven bits set: one more group would not fit
      if (acc[63:57] != '0) begin
        conclude(ST_OVERFLOW, '0, '0);
        return;
      end
      acc = {acc[56:0], r.data_byte[6:0]};
      if (r.data_byte[7]) return;
      v = acc;
      if (v == '0 || v > {48'd0, max_dim}) begin
        conclude((ph == PH_WIDTH) ? ST_WIDTH : ST_HEIGHT, '0, '0);
        return;
      end
      if (ph == PH_WIDTH) begin
        saved_w = v[15:0];
        acc = '0;
        ph = PH_HEIGHT;
        return;
      end
      conclude(ST_OK, saved_w, v[15:0]);
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_rsp;
      if (awaited_rsp.size() == 0) begin
        $error("unexpected result: status %0d width %0d height %0d",
               got.status, got.image_width, got.image_height);
        errors++;
        return;
      end
      exp_rsp = awaited_rsp.pop_front();
      if (got.status !== exp_rsp.status) begin
        $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
        errors++;
      end
      if (got.image_width !== exp_rsp.image_width) begin
        $error("image_width: expected %0d, got %0d", exp_rsp.image_width, got.image_width);
        errors++;
      end
      if (got.image_height !== exp_rsp.image_height) begin
        $error("image_height: expected %0d, got %0d", exp_rsp.image_height,
               got.image_height);
        errors++;
      end
    endfunction
  endclass

  header_checker sb = new();
  int unsigned   items_sent = 0;
  int unsigned   results_seen = 0;
  int unsigned   cycles = 0;
  bit            tx_calm = 1'b0;

  wbmp_header_parser_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[wbmp_header_parser_top] ERROR");
      $finish;
    end
  end

  task automatic send_req(input req_t r);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    items_sent++;
  endtask

  // wait for every awaited result, then let the last request clear the pipeline
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max(input logic [15:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_max(v);
  endtask

  function automatic void add_vlq(ref req_t hdr[$], input logic [34:0] v, input int pad);
    int   n;
    req_t r;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != '0) n++;
    r.end_of_input = 1'b0;
    // leading zero groups
    repeat (pad) begin
      r.data_byte = 8'h80;
      hdr.push_back(r);
    end
    for (int i = n - 1; i >= 0; i--) begin
      r.data_byte = {i != 0, v[7 * i +: 7]};
      hdr.push_back(r);
    end
  endfunction

  function automatic logic [34:0] pick_dim();
    int          p;
    logic [34:0] m;
    p = $urandom_range(0, 99);
    m = {19'd0, sb.max_dim};
    if (p < 55) return 35'($urandom_range(1, m));
    if (p < 70) return 35'($urandom_range(1, 127));
    if (p < 78) return '0;
    if (p < 86) return m;
    if (p < 92) return m + 1;
    return {3'($urandom), 32'($urandom)} >> $urandom_range(0, 34);
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  task automatic random_header();
    req_t hdr[$];
    req_t r;
    int   kind;
    int   cut;
    kind = $urandom_range(0, 99);
    tx_calm = ($urandom_range(0, 5) == 0);
    r.end_of_input = 1'b0;
    if (kind < 12) begin
      // noise
      repeat ($urandom_range(1, 6)) begin
        r.data_byte = 8'($urandom);
        r.end_of_input = ($urandom_range(0, 7) == 0);
        hdr.push_back(r);
      end
    end else begin
      r.data_byte = 8'h00;
      hdr.push_back(r);
      hdr.push_back(r);
      if (kind < 20) begin
        if ($urandom_range(0, 1)) hdr[0].data_byte = 8'($urandom_range(1, 255));
        else hdr[1].data_byte = 8'($urandom_range(1, 255));
      end else if (kind < 30) begin
        // long quantity that overflows the accumulator, in width or height
        if ($urandom_range(0, 1)) add_vlq(hdr, 35'($urandom_range(1, sb.max_dim)), 0);
        r.data_byte = {1'b1, 7'($urandom_range(2, 127))};
        hdr.push_back(r);
        repeat (8) begin
          r.data_byte = {1'b1, 7'($urandom)};
          hdr.push_back(r);
        end
        r.data_byte = 8'($urandom);
        hdr.push_back(r);
      end else begin
        add_vlq(hdr, pick_dim(), pick_pad());
        add_vlq(hdr, pick_dim(), pick_pad());
      end
    end
    if (hdr.size() > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, hdr.size() - 1);
      while (hdr.size() > cut) void'(hdr.pop_back());
      r.data_byte = 8'($urandom);
      r.end_of_input = 1'b1;
      hdr.push_back(r);
    end
    foreach (hdr[i]) send_req(hdr[i]);
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      int stall;
      stall = ((results_seen / 40) % 4 == 3) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_rsp_o);
      results_seen++;
    end
  end

  initial begin
    logic [8:0]  directed [23];
    logic [15:0] settings [8];
    int unsigned budget;
    directed = '{
      {8'h5A, 1'b1},
      {8'h01, 1'b0},
      {8'h00, 1'b0}, {8'h80, 1'b0},
      {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h83, 1'b0}, {8'hFF, 1'b0}, {8'h7F, 1'b0},
      {8'h01, 1'b0},
      {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0},
      {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h01, 1'b0}, {8'h84, 1'b0}, {8'h80, 1'b0},
      {8'h80, 1'b0}, {8'h00, 1'b0},
      {8'h00, 1'b0}, {8'h00, 1'b0}, {8'hC3, 1'b1}
    };
    settings = '{16'd1, 16'd0, 16'd127, 16'd128, 16'($urandom_range(1, 65535)),
                 16'hFFFF, 16'($urandom_range(300, 2000)), 16'd65534};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_req(req_t'(directed[i]));

    budget = ItemTarget / 8;
    foreach (settings[s]) begin
      write_max(settings[s]);
      while (items_sent < budget * (s + 1)) random_header();
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited_rsp.size() == 0)
      $display("[wbmp_header_parser_top] OK");
    else
      $display("[wbmp_header_parser_top] ERROR");
    $finish;
  end

endmodule
